// File: hdl/u16u8_pkg.sv
`default_nettype none

package u16u8_pkg;

  // configuration register indexes
  localparam logic CfgByteOrder   = 1'b0;
  localparam logic CfgMaxOutBytes = 1'b1;

  // byte order codes
  localparam logic [1:0] OrderBigEndian = 2'd2;

  localparam logic [15:0] MaxOutBytesReset = 16'hffff;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        end_of_string;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic [15:0] total_len;
    logic        string_done;
    logic        run_last;
  } out_item_t;

  // per-string conversion state
  typedef struct packed {
    logic [9:0]  held_high_bits;
    logic        held_valid;
    logic [15:0] bytes_written;
    logic        stopped;
  } conv_state_t;

  // results of one request, waiting to be sent
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      nbytes;
    logic            eos;
    logic [15:0]     base_len;
  } run_t;

endpackage

`default_nettype wire

// File: hdl/u16u8_decode.sv
`default_nettype none

module u16u8_decode (
  input  var u16u8_pkg::in_item_t    item_i,
  input  var u16u8_pkg::conv_state_t state_i,
  input  wire logic [1:0]            byte_order_i,
  input  wire logic [15:0]           max_out_bytes_i,
  output u16u8_pkg::conv_state_t     state_o,
  output u16u8_pkg::run_t            run_o
);

  logic [15:0] unit;
  logic        halt;
  logic        have;
  logic [20:0] cp;
  logic [2:0]  len;
  logic [3:0][7:0] enc;
  logic [15:0] remaining;
  logic        fits;
  u16u8_pkg::conv_state_t nxt;

  always_comb begin
    unit = (byte_order_i == u16u8_pkg::OrderBigEndian) ?
           {item_i.code_unit[7:0], item_i.code_unit[15:8]} : item_i.code_unit;
    nxt  = state_i;
    have = 1'b0;
    cp   = '0;
    // spent budget stops the string and drops a held unit
    if (!state_i.stopped && (state_i.bytes_written >= max_out_bytes_i)) begin
      nxt.stopped    = 1'b1;
      nxt.held_valid = 1'b0;
    end
    halt = nxt.stopped;
    if (!halt) begin
      if (state_i.held_valid && (unit[15:10] == 6'b110111)) begin
        cp             = 21'h010000 + {1'b0, state_i.held_high_bits, unit[9:0]};
        have           = 1'b1;
        nxt.held_valid = 1'b0;
      end else begin
        nxt.held_valid = 1'b0;
        if (unit == 16'h0000) begin
          nxt.stopped = 1'b1;
        end else if (unit[15:11] == 5'b11011) begin
          if (!unit[10]) begin
            nxt.held_high_bits = unit[9:0];
            nxt.held_valid     = 1'b1;
          end
        end else begin
          cp   = {5'b0, unit};
          have = 1'b1;
        end
      end
    end
  end

  always_comb begin
    enc = '0;
    if (cp <= 21'h00007f) begin
      len    = 3'd1;
      enc[0] = cp[7:0];
    end else if (cp <= 21'h0007ff) begin
      len    = 3'd2;
      enc[0] = {3'b110, cp[10:6]};
      enc[1] = {2'b10, cp[5:0]};
    end else if (cp <= 21'h00ffff) begin
      len    = 3'd3;
      enc[0] = {4'b1110, cp[15:12]};
      enc[1] = {2'b10, cp[11:6]};
      enc[2] = {2'b10, cp[5:0]};
    end else begin
      len    = 3'd4;
      enc[0] = {5'b11110, cp[20:18]};
      enc[1] = {2'b10, cp[17:12]};
      enc[2] = {2'b10, cp[11:6]};
      enc[3] = {2'b10, cp[5:0]};
    end
    // bytes_written is below the budget whenever a character is formed
    remaining = max_out_bytes_i - state_i.bytes_written;
    fits      = have && ({13'b0, len} <= remaining);
  end

  always_comb begin
    run_o.bytes    = enc;
    run_o.nbytes   = fits ? len : 3'd0;
    run_o.eos      = item_i.end_of_string;
    run_o.base_len = state_i.bytes_written;
    state_o        = nxt;
    state_o.bytes_written = state_i.bytes_written + {13'b0, run_o.nbytes};
    if (item_i.end_of_string) begin
      state_o = '0;
    end
  end

endmodule

`default_nettype wire

// File: hdl/u16u8_drain.sv
`default_nettype none

module u16u8_drain (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             load_i,
  input  var u16u8_pkg::run_t   run_i,
  output logic                  free_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output u16u8_pkg::out_item_t  out_o
);

  u16u8_pkg::run_t run_q;
  logic            busy_q;
  logic [2:0]      idx_q;
  logic [2:0]      count;
  logic            last_now;
  logic            is_byte;

  always_comb begin
    count    = run_q.nbytes + {2'b0, run_q.eos};
    last_now = (idx_q + 3'd1) == count;
    is_byte  = idx_q < run_q.nbytes;
    free_o   = !busy_q || (out_ready_i && last_now);

    out_valid_o       = busy_q;
    out_o.out_byte    = is_byte ? run_q.bytes[idx_q[1:0]] : 8'h00;
    out_o.byte_valid  = is_byte;
    out_o.total_len   = run_q.base_len + {13'b0, idx_q} + {15'b0, is_byte};
    out_o.string_done = !is_byte;
    out_o.run_last    = last_now;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (load_i) begin
      busy_q <= (run_i.nbytes != 3'd0) || run_i.eos;
      idx_q  <= '0;
    end else if (busy_q && out_ready_i) begin
      if (last_now) begin
        busy_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      run_q <= run_i;
    end
  end

`ifndef SYNTHESIS
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> (!busy_q || (out_ready_i && last_now)))
    else $error("run loaded over unsent results");
  a_close_only_unbyte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_o.byte_valid) |-> (out_o.string_done && out_o.run_last))
    else $error("result without byte is not a closing result");
  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !out_o.run_last) |=> out_valid_o)
    else $error("run cut short");
  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (idx_q < count))
    else $error("result index beyond run");
`endif

endmodule

`default_nettype wire

// File: hdl/utf16_to_utf8_stream.sv
// flow: a request is held in the input register, then its run is loaded into the drain
//   register once the drain stage is free, and the drain stage offers its first result
// throughput: one result per cycle while out_ready_i is high, set by the single-result
//   drain stage; a request yields up to five results, its bytes and an end mark
// reset: asynchronous active low; clears control, string state and registers
//   (byte order host, budget 65535)
`default_nettype none

module utf16_to_utf8_stream (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // configuration write port
  input  wire logic                 cfg_we_i,
  input  wire logic                 cfg_idx_i,
  input  wire logic [15:0]          cfg_data_i,
  // code unit requests
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  var u16u8_pkg::in_item_t   in_i,
  // utf-8 results
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output u16u8_pkg::out_item_t      out_o
);

  // configuration registers
  logic [1:0]  byte_order_q;
  logic [15:0] max_out_bytes_q;

  // input register
  logic                  in_valid_q;
  u16u8_pkg::in_item_t   in_q;

  // string state, updated as each request moves to the drain stage
  u16u8_pkg::conv_state_t state_q;
  u16u8_pkg::conv_state_t state_d;
  u16u8_pkg::run_t        run;

  logic free;
  logic load;

  // a request leaves the input register once the drain stage can take its run;
  // the input register refills in the same cycle
  assign load       = in_valid_q && free;
  assign in_ready_o = !in_valid_q || load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_order_q    <= '0;
      max_out_bytes_q <= u16u8_pkg::MaxOutBytesReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        u16u8_pkg::CfgByteOrder:   byte_order_q    <= cfg_data_i[1:0];
        u16u8_pkg::CfgMaxOutBytes: max_out_bytes_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      state_q    <= '0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (load) begin
        state_q <= state_d;
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_i;
    end
  end

  // surrogate pairing, budget check and utf-8 encoding of one unit
  u16u8_decode u_decode (
    .item_i          (in_q),
    .state_i         (state_q),
    .byte_order_i    (byte_order_q),
    .max_out_bytes_i (max_out_bytes_q),
    .state_o         (state_d),
    .run_o           (run)
  );

  // holds one run of up to five results and sends them one per cycle while out_ready_i is high
  u16u8_drain u_drain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .run_i       (run),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire
